/* src/ogg_pms_pkg.sv */
// ----------------------------------------------------------------------------
// Ogg page metadata scanner package
// Phase codes and match patterns shared by the scanner logic.
// ----------------------------------------------------------------------------
package ogg_pms_pkg;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_SEGTAB = 2'd2,
      PH_BODY   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_ID    = 2'd1,
      ST_ZERO_VAL = 2'd2
   } status_type;

   localparam logic [4:0] HEADER_LAST    = 5'd26;
   localparam logic [4:0] VER_OFFSET     = 5'd5;
   localparam logic [4:0] GRAN_FIRST     = 5'd6;
   localparam logic [4:0] GRAN_LAST      = 5'd13;
   localparam logic [4:0] ID_MIN_BODY    = 5'd7;
   localparam logic [4:0] ID_SPAN        = 5'd16;
   localparam logic [4:0] ID_CHANNELS_AT = 5'd11;
   localparam logic [4:0] ID_RATE_AT     = 5'd12;
   localparam logic [4:0] CAPTURE_LEN    = 5'd4;

   localparam int unsigned RSP_DATA_W = 112;

   localparam logic [7:0] CAPTURE_O = 8'h4F;

   // "OggS"
   function automatic logic [7:0] capture_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h4F;
         2'd1:    val = 8'h67;
         2'd2:    val = 8'h67;
         default: val = 8'h53;
      endcase
      return val;
   endfunction

   // 0x01 "vorbis"
   function automatic logic [7:0] vorbis_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'h01;
         3'd1:    val = 8'h76;
         3'd2:    val = 8'h6F;
         3'd3:    val = 8'h72;
         3'd4:    val = 8'h62;
         3'd5:    val = 8'h69;
         3'd6:    val = 8'h73;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

/* src/ogg_page_metadata_scanner.sv */
// ----------------------------------------------------------------------------
// Ogg page metadata scanner
// Walks Ogg pages in a byte stream and reports Vorbis id fields and the
// last positive granule position at the end of each file.
// ----------------------------------------------------------------------------
// One file byte is taken per clock, back to back; the page walker updates all
// of its state in the cycle the word is accepted. The word marked tlast puts
// one result into the output register, visible the next cycle; the input is
// stalled only while that register holds a result the sink has not taken.
// After the final byte all scanning state returns to its reset value, so the
// following word starts a new file. No result is produced for other words.
module ogg_page_metadata_scanner (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last byte of the file
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] status, [9:2] channels, [41:10] rate,
   // [105:42] total_samples, [111:106] zero
   output logic [ogg_pms_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   ogg_pms_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  header_offset_ff, header_offset_in;
   logic [7:0]  segments_left_ff, segments_left_in;
   logic [15:0] body_left_ff, body_left_in;
   logic [63:0] granule_ff, granule_in;
   logic [4:0]  body_offset_ff, body_offset_in;
   logic        signature_ok_ff, signature_ok_in;
   logic [7:0]  pending_channels_ff, pending_channels_in;
   logic [31:0] pending_rate_ff, pending_rate_in;
   logic        id_seen_ff, id_seen_in;
   logic [7:0]  kept_channels_ff, kept_channels_in;
   logic [31:0] kept_rate_ff, kept_rate_in;
   logic [63:0] kept_total_ff, kept_total_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [ogg_pms_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic        req_accept;
   logic [7:0]  b;

   assign b          = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // Page walker next state
   always_comb begin
      ogg_pms_pkg::phase_type ph;
      logic [4:0]  ho;
      logic [7:0]  sl;
      logic [15:0] bl;
      logic [63:0] gr;
      logic [4:0]  bo;
      logic        sok;
      logic [7:0]  pch;
      logic [31:0] prt;
      logic        ids;
      logic [7:0]  kch;
      logic [31:0] krt;
      logic [63:0] ktot;
      logic        was_body;
      logic        do_begin;
      logic        do_finish;
      logic        do_commit;

      ph   = phase_ff;
      ho   = header_offset_ff;
      sl   = segments_left_ff;
      bl   = body_left_ff;
      gr   = granule_ff;
      bo   = body_offset_ff;
      sok  = signature_ok_ff;
      pch  = pending_channels_ff;
      prt  = pending_rate_ff;
      ids  = id_seen_ff;
      kch  = kept_channels_ff;
      krt  = kept_rate_ff;
      ktot = kept_total_ff;
      was_body  = (phase_ff == ogg_pms_pkg::PH_BODY);
      do_begin  = 1'b0;
      do_finish = 1'b0;
      do_commit = 1'b0;

      // id capture over the 16 bytes after a candidate body start
      if (sok && bo < ogg_pms_pkg::ID_SPAN) begin
         if (bo < ogg_pms_pkg::ID_MIN_BODY) begin
            if (b != ogg_pms_pkg::vorbis_byte(bo[2:0])) begin
               sok = 1'b0;
            end
         end else if (bo == ogg_pms_pkg::ID_CHANNELS_AT) begin
            pch = b;
         end else if (bo >= ogg_pms_pkg::ID_RATE_AT) begin
            case (bo[1:0])
               2'd0:    prt[7:0]   = b;
               2'd1:    prt[15:8]  = b;
               2'd2:    prt[23:16] = b;
               default: prt[31:24] = b;
            endcase
         end
         if (sok) begin
            bo = bo + 5'd1;
            if (bo == ogg_pms_pkg::ID_SPAN && !was_body) begin
               do_commit = 1'b1;
            end
         end
      end
      if (do_commit) begin
         if (!ids) begin
            kch = pch;
            krt = prt;
            ids = 1'b1;
         end
         sok = 1'b0;
      end

      unique case (phase_ff)
         ogg_pms_pkg::PH_HUNT: begin
            if (ho < ogg_pms_pkg::CAPTURE_LEN) begin
               if (b == ogg_pms_pkg::capture_byte(ho[1:0])) begin
                  ho = ho + 5'd1;
               end else begin
                  ho = (b == ogg_pms_pkg::CAPTURE_O) ? 5'd1 : 5'd0;
               end
            end else if (b == 8'd0) begin
               ph = ogg_pms_pkg::PH_HEADER;
               ho = ogg_pms_pkg::VER_OFFSET;
               gr = '0;
            end else begin
               // rescan from the version byte itself
               ho = (b == ogg_pms_pkg::CAPTURE_O) ? 5'd1 : 5'd0;
            end
         end
         ogg_pms_pkg::PH_HEADER: begin
            if (ho >= ogg_pms_pkg::GRAN_FIRST && ho <= ogg_pms_pkg::GRAN_LAST) begin
               gr = {b, gr[63:8]};
            end
            if (ho >= ogg_pms_pkg::HEADER_LAST) begin
               sl = b;
               bl = '0;
               if (b == 8'd0) begin
                  do_begin = 1'b1;
               end else begin
                  ph = ogg_pms_pkg::PH_SEGTAB;
               end
            end else begin
               ho = ho + 5'd1;
            end
         end
         ogg_pms_pkg::PH_SEGTAB: begin
            bl = bl + {8'd0, b};
            sl = sl - 8'd1;
            if (sl == 8'd0) begin
               do_begin = 1'b1;
            end
         end
         ogg_pms_pkg::PH_BODY: begin
            bl = bl - 16'd1;
            if (bl == 16'd0) begin
               do_finish = 1'b1;
            end
         end
         default: begin
            ph = ogg_pms_pkg::PH_HUNT;
            ho = '0;
         end
      endcase

      if (do_begin) begin
         ho = '0;
         if (bl == 16'd0) begin
            do_finish = 1'b1;
         end else begin
            ph = ogg_pms_pkg::PH_BODY;
            if (!ids && bl >= {11'd0, ogg_pms_pkg::ID_MIN_BODY}) begin
               sok = 1'b1;
               bo  = '0;
               pch = '0;
               prt = '0;
            end
         end
      end

      if (do_finish) begin
         ph = ogg_pms_pkg::PH_HUNT;
         ho = '0;
         if (!gr[63] && gr != 64'd0) begin
            ktot = gr;
         end
         if (sok && bo >= ogg_pms_pkg::ID_SPAN) begin
            if (!ids) begin
               kch = pch;
               krt = prt;
               ids = 1'b1;
            end
            sok = 1'b0;
         end
      end

      phase_in            = phase_ff;
      header_offset_in    = header_offset_ff;
      segments_left_in    = segments_left_ff;
      body_left_in        = body_left_ff;
      granule_in          = granule_ff;
      body_offset_in      = body_offset_ff;
      signature_ok_in     = signature_ok_ff;
      pending_channels_in = pending_channels_ff;
      pending_rate_in     = pending_rate_ff;
      id_seen_in          = id_seen_ff;
      kept_channels_in    = kept_channels_ff;
      kept_rate_in        = kept_rate_ff;
      kept_total_in       = kept_total_ff;

      if (req_accept) begin
         if (req_tlast) begin
            // end of file: start over for the next one
            phase_in            = ogg_pms_pkg::PH_HUNT;
            header_offset_in    = '0;
            segments_left_in    = '0;
            body_left_in        = '0;
            granule_in          = '0;
            body_offset_in      = '0;
            signature_ok_in     = 1'b0;
            pending_channels_in = '0;
            pending_rate_in     = '0;
            id_seen_in          = 1'b0;
            kept_channels_in    = '0;
            kept_rate_in        = '0;
            kept_total_in       = '1;
         end else begin
            phase_in            = ph;
            header_offset_in    = ho;
            segments_left_in    = sl;
            body_left_in        = bl;
            granule_in          = gr;
            body_offset_in      = bo;
            signature_ok_in     = sok;
            pending_channels_in = pch;
            pending_rate_in     = prt;
            id_seen_in          = ids;
            kept_channels_in    = kch;
            kept_rate_in        = krt;
            kept_total_in       = ktot;
         end
      end

      // result word from the state this byte leaves
      if (!ids) begin
         rsp_data_in = {6'd0, ktot, 32'd0, 8'd0, ogg_pms_pkg::ST_NO_ID};
      end else if (kch == 8'd0 || krt == 32'd0) begin
         rsp_data_in = {6'd0, ktot, krt, kch, ogg_pms_pkg::ST_ZERO_VAL};
      end else begin
         rsp_data_in = {6'd0, ktot, krt, kch, ogg_pms_pkg::ST_OK};
      end
   end

   // Output register control
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && req_tlast) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= ogg_pms_pkg::PH_HUNT;
         header_offset_ff    <= '0;
         segments_left_ff    <= '0;
         body_left_ff        <= '0;
         granule_ff          <= '0;
         body_offset_ff      <= '0;
         signature_ok_ff     <= 1'b0;
         pending_channels_ff <= '0;
         pending_rate_ff     <= '0;
         id_seen_ff          <= 1'b0;
         kept_channels_ff    <= '0;
         kept_rate_ff        <= '0;
         kept_total_ff       <= '1;
         rsp_valid_ff        <= 1'b0;
      end else begin
         phase_ff            <= phase_in;
         header_offset_ff    <= header_offset_in;
         segments_left_ff    <= segments_left_in;
         body_left_ff        <= body_left_in;
         granule_ff          <= granule_in;
         body_offset_ff      <= body_offset_in;
         signature_ok_ff     <= signature_ok_in;
         pending_channels_ff <= pending_channels_in;
         pending_rate_ff     <= pending_rate_in;
         id_seen_ff          <= id_seen_in;
         kept_channels_ff    <= kept_channels_in;
         kept_rate_ff        <= kept_rate_in;
         kept_total_ff       <= kept_total_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_tlast) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> rsp_valid_ff)
      else $error("final byte did not load a result");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=>
         (phase_ff == ogg_pms_pkg::PH_HUNT && !id_seen_ff && kept_total_ff == '1))
      else $error("scanner state not cleared after final byte");

   a_capture_bound: assert property (@(posedge clock) disable iff (reset)
      signature_ok_ff |-> (body_offset_ff <= ogg_pms_pkg::ID_SPAN && !id_seen_ff))
      else $error("id capture active out of range");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[1:0] != 2'd3))
      else $error("invalid status code in result");

endmodule

/* verif/ogg_report_check.sv */
// ----------------------------------------------------------------------------
// Ogg scanner report checker
// Watches the byte channel and the report channel of the scanner. It tracks
// page state byte by byte on its own, builds the report that each end-of-file
// word should give, and compares every report field by field, in order.
// ----------------------------------------------------------------------------
module ogg_report_check (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   input  logic                               req_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [ogg_pms_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int unsigned                        mismatch_total,
   output int unsigned                        reports_waiting,
   output int unsigned                        reports_checked
);

   // "OggS" and 0x01 "vorbis", first byte in the lowest bits
   localparam logic [31:0] SYNC_WORD  = 32'h5367_674F;
   localparam logic [55:0] VORBIS_TAG = 56'h73_6962_726F_7601;

   typedef struct packed {
      ogg_pms_pkg::status_type status;
      logic [7:0]              channels;
      logic [31:0]             rate;
      logic [63:0]             total;
   } scan_report_type;

   scan_report_type reports_due[$];

   ogg_pms_pkg::phase_type phase;
   logic [4:0]  header_offset;
   logic [7:0]  seg_left;
   logic [15:0] body_left;
   logic [63:0] granule;
   logic [4:0]  id_offset;
   logic        sig_armed;
   logic [7:0]  cand_channels;
   logic [31:0] cand_rate;
   logic        id_taken;
   logic [7:0]  kept_channels;
   logic [31:0] kept_rate;
   logic [63:0] kept_total;

   int unsigned errors;
   int unsigned checked;

   task automatic clear_scan();
      phase         = ogg_pms_pkg::PH_HUNT;
      header_offset = '0;
      seg_left      = '0;
      body_left     = '0;
      granule       = '0;
      id_offset     = '0;
      sig_armed     = 1'b0;
      cand_channels = '0;
      cand_rate     = '0;
      id_taken      = 1'b0;
      kept_channels = '0;
      kept_rate     = '0;
      kept_total    = '1;
   endtask

   // only the first id page counts; a later candidate is dropped
   task automatic take_id();
      if (!id_taken) begin
         kept_channels = cand_channels;
         kept_rate     = cand_rate;
         id_taken      = 1'b1;
      end
      sig_armed = 1'b0;
   endtask

   task automatic close_page();
      phase         = ogg_pms_pkg::PH_HUNT;
      header_offset = '0;
      if (!granule[63] && granule != 64'd0)
         kept_total = granule;
      if (sig_armed && id_offset >= ogg_pms_pkg::ID_SPAN)
         take_id();
   endtask

   task automatic open_body();
      header_offset = '0;
      if (body_left == 16'd0) begin
         close_page();
      end else begin
         phase = ogg_pms_pkg::PH_BODY;
         if (!id_taken && body_left >= 16'(ogg_pms_pkg::ID_MIN_BODY)) begin
            sig_armed     = 1'b1;
            id_offset     = '0;
            cand_channels = '0;
            cand_rate     = '0;
         end
      end
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic is_last);
      logic            was_body;
      logic [4:0]      o;
      scan_report_type rep;
      was_body = (phase == ogg_pms_pkg::PH_BODY);

      // the 16 bytes after a body start are captured even past the page end
      if (sig_armed && id_offset < ogg_pms_pkg::ID_SPAN) begin
         o = id_offset;
         if (o < ogg_pms_pkg::ID_MIN_BODY) begin
            if (b != VORBIS_TAG[8*o +: 8])
               sig_armed = 1'b0;
         end else if (o == ogg_pms_pkg::ID_CHANNELS_AT) begin
            cand_channels = b;
         end else if (o >= ogg_pms_pkg::ID_RATE_AT) begin
            cand_rate = cand_rate | (32'(b) << (8 * (o - ogg_pms_pkg::ID_RATE_AT)));
         end
         if (sig_armed) begin
            id_offset = o + 5'd1;
            if (id_offset == ogg_pms_pkg::ID_SPAN && !was_body)
               take_id();
         end
      end

      case (phase)
         ogg_pms_pkg::PH_HUNT: begin
            if (header_offset < ogg_pms_pkg::CAPTURE_LEN) begin
               if (b == SYNC_WORD[8*header_offset[1:0] +: 8])
                  header_offset = header_offset + 5'd1;
               else
                  header_offset = (b == SYNC_WORD[7:0]) ? 5'd1 : 5'd0;
            end else if (b == 8'd0) begin
               phase         = ogg_pms_pkg::PH_HEADER;
               header_offset = ogg_pms_pkg::VER_OFFSET;
               granule       = '0;
            end else begin
               // bad version: the byte itself may open a new pattern
               header_offset = (b == SYNC_WORD[7:0]) ? 5'd1 : 5'd0;
            end
         end
         ogg_pms_pkg::PH_HEADER: begin
            if (header_offset >= ogg_pms_pkg::GRAN_FIRST &&
                header_offset <= ogg_pms_pkg::GRAN_LAST)
               granule = {b, granule[63:8]};
            if (header_offset >= ogg_pms_pkg::HEADER_LAST) begin
               seg_left  = b;
               body_left = '0;
               if (b == 8'd0)
                  open_body();
               else
                  phase = ogg_pms_pkg::PH_SEGTAB;
            end else begin
               header_offset = header_offset + 5'd1;
            end
         end
         ogg_pms_pkg::PH_SEGTAB: begin
            body_left = body_left + 16'(b);
            seg_left  = seg_left - 8'd1;
            if (seg_left == 8'd0)
               open_body();
         end
         default: begin
            body_left = body_left - 16'd1;
            if (body_left == 16'd0)
               close_page();
         end
      endcase

      if (is_last) begin
         if (!id_taken) begin
            rep.status   = ogg_pms_pkg::ST_NO_ID;
            rep.channels = '0;
            rep.rate     = '0;
         end else begin
            rep.status   = (kept_channels == 8'd0 || kept_rate == 32'd0)
                           ? ogg_pms_pkg::ST_ZERO_VAL : ogg_pms_pkg::ST_OK;
            rep.channels = kept_channels;
            rep.rate     = kept_rate;
         end
         rep.total = kept_total;
         reports_due.insert(reports_due.size(), rep);
         clear_scan();
      end
   endtask

   always @(posedge clock) begin
      scan_report_type want;
      logic [1:0]      got_status;
      logic [7:0]      got_channels;
      logic [31:0]     got_rate;
      logic [63:0]     got_total;
      if (reset) begin
         clear_scan();
         reports_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_status   = rsp_tdata[1:0];
            got_channels = rsp_tdata[9:2];
            got_rate     = rsp_tdata[41:10];
            got_total    = rsp_tdata[105:42];
            if (reports_due.size() == 0) begin
               if (errors < 10)
                  $display("unexpected report: status %0d channels %0d rate %0d total %0d",
                           got_status, got_channels, got_rate, $signed(got_total));
               errors++;
            end else begin
               want = reports_due.pop_front();
               checked++;
               if (got_status !== want.status || got_channels !== want.channels ||
                   got_rate !== want.rate || got_total !== want.total) begin
                  if (errors < 10) begin
                     $display("report %0d mismatch:", checked);
                     $display("  status   exp %0d got %0d", want.status, got_status);
                     $display("  channels exp %0d got %0d", want.channels, got_channels);
                     $display("  rate     exp %0d got %0d", want.rate, got_rate);
                     $display("  total    exp %0d got %0d",
                              $signed(want.total), $signed(got_total));
                  end
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            scan_byte(req_tdata, req_tlast);
      end
      mismatch_total  <= errors;
      reports_waiting <= reports_due.size();
      reports_checked <= checked;
   end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Ogg page metadata scanner testbench
// Streams byte files into the scanner: a few hand-built files first, then
// random files made mostly of well-formed pages with random content, noise
// and cut-off endings. Both channels idle at random; the checker predicts
// and compares every end-of-file report.
// ----------------------------------------------------------------------------
module tb;

   typedef enum int {
      BODY_PLAIN,
      BODY_ID,
      BODY_ID_BROKEN
   } body_kind_type;

   typedef enum int {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_SPARSE,
      RDY_HOLD
   } ready_mode_type;

   localparam int unsigned WORD_TARGET = 1850;
   localparam int unsigned FILE_TARGET = 12;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [7:0]                         req_tdata  = '0;
   logic                               req_tlast  = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [ogg_pms_pkg::RSP_DATA_W-1:0] rsp_tdata;

   int unsigned mismatch_total;
   int unsigned reports_waiting;
   int unsigned reports_checked;

   logic [7:0]  file_bytes[$];
   int unsigned files_sent = 0;
   int unsigned words_sent = 0;
   int unsigned burst_left = 0;
   bit          valid_up   = 1'b0;

   ready_mode_type ready_mode = RDY_ALWAYS;
   int unsigned    ready_hold = 0;

   always #2 clock = ~clock;

   ogg_page_metadata_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ogg_report_check report_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_total  (mismatch_total),
      .reports_waiting (reports_waiting),
      .reports_checked (reports_checked)
   );

   // sink: switch at random between ready patterns: always, coin flip, sparse, held low
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_hold = $urandom_range(8, 64);
      end else begin
         ready_hold--;
      end
      case (ready_mode)
         RDY_ALWAYS: rsp_tready <= 1'b1;
         RDY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RDY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:    rsp_tready <= 1'b0;
      endcase
   end

   function automatic logic [63:0] pick_granule();
      logic [63:0] g;
      case ($urandom_range(0, 7))
         0:       g = 64'd0;
         1:       g = {1'b1, 31'($urandom), 32'($urandom)};
         2:       g = 64'h7FFF_FFFF_FFFF_FFFF;
         3:       g = 64'hFFFF_FFFF_FFFF_FFFF;
         4:       g = 64'd1;
         5:       g = {1'b0, 31'($urandom), 32'($urandom)};
         default: g = 64'($urandom_range(1, 200000));
      endcase
      return g;
   endfunction

   function automatic logic [7:0] pick_version();
      logic [7:0] v;
      case ($urandom_range(0, 11))
         0:       v = 8'h4F;
         1:       v = 8'($urandom_range(1, 255));
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] pick_channels();
      logic [7:0] c;
      case ($urandom_range(0, 5))
         0:       c = 8'd0;
         1:       c = 8'd255;
         default: c = 8'($urandom_range(1, 8));
      endcase
      return c;
   endfunction

   function automatic logic [31:0] pick_rate();
      logic [31:0] r;
      case ($urandom_range(0, 5))
         0:       r = 32'd0;
         1:       r = 32'hFFFF_FFFF;
         2:       r = 32'd44100;
         3:       r = 32'd48000;
         default: r = $urandom;
      endcase
      return r;
   endfunction

   task automatic append_byte(input logic [7:0] v);
      file_bytes.insert(file_bytes.size(), v);
   endtask

   // noise leans toward pattern bytes so that partial matches happen often
   task automatic add_noise(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0:       append_byte(8'h4F);
            1:       append_byte(8'h67);
            2:       append_byte(8'h53);
            3:       append_byte(8'h00);
            default: append_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   // a negative segment count or length picks one at random
   task automatic add_page(input body_kind_type kind, input logic [63:0] gran,
                           input logic [7:0] version, input int nseg, input int seglen,
                           input logic [7:0] chans, input logic [31:0] rate);
      int          lens[$];
      int          total;
      int          flip;
      logic [7:0]  body[$];
      logic [55:0] tag;
      logic [7:0]  b;
      tag   = 56'h73_6962_726F_7601;
      total = 0;
      if (nseg < 0) begin
         case ($urandom_range(0, 9))
            0:       nseg = 0;
            1:       nseg = $urandom_range(4, 12);
            default: nseg = $urandom_range(1, 3);
         endcase
      end
      for (int k = 0; k < nseg; k++) begin
         if (seglen >= 0)
            lens.insert(lens.size(), seglen);
         else if ($urandom_range(0, 59) == 0)
            lens.insert(lens.size(), 255);
         else if ($urandom_range(0, 9) == 0)
            lens.insert(lens.size(), $urandom_range(0, 60));
         else
            lens.insert(lens.size(), $urandom_range(0, 12));
         total += lens[k];
      end

      append_byte(8'h4F);
      append_byte(8'h67);
      append_byte(8'h67);
      append_byte(8'h53);
      append_byte(version);
      append_byte(8'($urandom_range(0, 255)));
      for (int k = 0; k < 8; k++)
         append_byte(gran[8*k +: 8]);
      // serial, sequence and checksum are ignored by the scanner
      for (int k = 0; k < 12; k++)
         append_byte(8'($urandom_range(0, 255)));
      append_byte(8'(nseg));
      foreach (lens[k])
         append_byte(8'(lens[k]));

      for (int k = 0; k < total; k++) begin
         b = 8'($urandom_range(0, 255));
         if (kind != BODY_PLAIN) begin
            if (k < 7)
               b = tag[8*k +: 8];
            else if (k == 11)
               b = chans;
            else if (k >= 12 && k < 16)
               b = rate[8*(k-12) +: 8];
         end
         body.insert(body.size(), b);
      end
      if (kind == BODY_ID_BROKEN) begin
         flip = $urandom_range(0, 6);
         if (flip < total)
            body[flip] = body[flip] ^ (8'd1 << $urandom_range(0, 7));
      end
      foreach (body[k])
         append_byte(body[k]);
   endtask

   task automatic push_word(input logic [7:0] b, input logic is_last);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      valid_up    = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            valid_up    = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++)
         push_word(file_bytes[i], i == file_bytes.size() - 1);
      files_sent++;
      file_bytes.delete();
   endtask

   task automatic build_random_file();
      int            npages;
      int            keep;
      body_kind_type kind;
      npages = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      if (npages == 0)
         add_noise($urandom_range(1, 12));
      for (int p = 0; p < npages; p++) begin
         if ($urandom_range(0, 3) == 0)
            add_noise($urandom_range(1, 6));
         case ($urandom_range(0, 9))
            0, 1:    kind = (p == 0) ? BODY_ID_BROKEN : BODY_ID;
            2, 3, 4: kind = (p == 0) ? BODY_ID : BODY_PLAIN;
            5, 6:    kind = (p == 0) ? BODY_ID : BODY_PLAIN;
            default: kind = BODY_PLAIN;
         endcase
         add_page(kind, pick_granule(), pick_version(), -1, -1,
                  pick_channels(), pick_rate());
      end
      if ($urandom_range(0, 2) == 0)
         add_noise($urandom_range(1, 4));
      // cut the file short: the final page may never complete
      if ($urandom_range(0, 4) == 0 && file_bytes.size() > 1) begin
         keep = $urandom_range(1, file_bytes.size() - 1);
         while (file_bytes.size() > keep)
            void'(file_bytes.pop_back());
      end
      if (file_bytes.size() == 0)
         append_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // one-byte files at both byte extremes
      append_byte(8'hFF);
      send_file();
      append_byte(8'h00);
      send_file();

      // id page, then a page with a negative granule that must not stick
      add_page(BODY_ID, 64'd88200, 8'h00, 2, 10, 8'd2, 32'd44100);
      add_page(BODY_PLAIN, 64'h8000_0000_0000_0005, 8'h00, 1, 3, 8'd0, 32'd0);
      send_file();

      // bad version that reopens the pattern, short id body, empty pages
      append_byte(8'h4F);
      append_byte(8'h67);
      append_byte(8'h67);
      append_byte(8'h53);
      add_page(BODY_ID, 64'd7, 8'h00, 1, 9, 8'd1, 32'd22050);
      add_page(BODY_PLAIN, 64'd0, 8'h00, 0, 0, 8'd0, 32'd0);
      add_page(BODY_PLAIN, 64'd3, 8'h00, 3, 0, 8'd0, 32'd0);
      send_file();

      // zero channels
      add_page(BODY_ID, 64'd1, 8'h00, 1, 16, 8'd0, 32'd48000);
      send_file();

      // broken tag, foreign version, then a cut-off id page
      add_page(BODY_ID_BROKEN, 64'd9, 8'h00, 2, 10, 8'd2, 32'd44100);
      add_page(BODY_ID, 64'd11, 8'h01, 1, 20, 8'd2, 32'd44100);
      add_page(BODY_ID, 64'd12, 8'h00, 2, 10, 8'd2, 32'd44100);
      repeat (5) void'(file_bytes.pop_back());
      send_file();

      // largest positive granule, zero rate, widest channel count
      add_page(BODY_ID, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00, 1, 30, 8'd255, 32'd0);
      add_page(BODY_PLAIN, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1, 255, 8'd0, 32'd0);
      send_file();

      while (words_sent < WORD_TARGET || files_sent < FILE_TARGET) begin
         build_random_file();
         send_file();
      end

      if (valid_up)
         req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_waiting != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d files in %0d byte words; %0d end-of-file reports compared",
               files_sent, words_sent, reports_checked);
      if (mismatch_total == 0 && reports_waiting == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
src/ogg_pms_pkg.sv
src/ogg_page_metadata_scanner.sv
verif/ogg_report_check.sv
verif/tb.sv
